FILE: design/svoq_pkg.sv
// Shared types and constants for the sparse voxel octree query unit.
// Used by the front end, the command queue, the back end and the top level.
package svoq_pkg;

  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 13;
  localparam int WORD_W     = 32;
  localparam int COORD_W    = 19;
  localparam int POS_W      = COORD_W - 1;
  localparam int DEPTH_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int BASE_W     = 24;
  localparam int MASK_W     = 8;

  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = 2;
  localparam int CMD_CNT_W  = 3;

  localparam logic [WORD_W-1:0] FULL_NODE = 32'hff000000;

  localparam logic [KIND_W-1:0] KIND_NODE_WR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEAF_WR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TREE_DEPTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_PRESENT = 3'd4;

  typedef enum logic [1:0] {
    OP_NODE_WR = 2'd0,
    OP_LEAF_WR = 2'd1,
    OP_ZERO    = 2'd2,
    OP_WALK    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  address;
    logic [WORD_W-1:0]  word;
    logic [DEPTH_W-1:0] depth;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [POS_W-1:0]   z;
  } cmd_t;

endpackage

FILE: design/sparse_voxel_octree_query_unit.sv
// Sparse voxel octree point query unit: top level joining front end, queue, back end.
// Depends on svoq_pkg, svoq_front, svoq_cmd_fifo and svoq_back.
//
// Node and leaf words are loaded by write beats (kind 0 and 1); a query beat
// (kind 2) returns one solid bit, writes and kind 3 return nothing. Query beats
// and in-range write beats enter a four-entry command queue and are carried out
// in order. A write, or a query that is outside the grid or finds no tree, is
// done when it is popped; a walking query reads the root node as it is popped,
// then at most one node per level of depth, where depth is tree_depth capped at
// MAX_DEPTH, then one leaf store word, and may end early on a full node or a missing child.
// A query waits in the back end, and holds the commands behind it, until the
// previous result is taken from the output register.
// Store entries that were never written read as unknown data.
module sparse_voxel_octree_query_unit #(
  parameter int NODE_WORDS = 4096,
  parameter int LEAF_WORDS = 8192,
  parameter int MAX_DEPTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [svoq_pkg::KIND_W-1:0]          kind,
  input  logic [svoq_pkg::ADDR_W-1:0]          address,
  input  logic [svoq_pkg::WORD_W-1:0]          word,
  input  logic signed [svoq_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [svoq_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [svoq_pkg::COORD_W-1:0]  coord_z,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 solid,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [svoq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [svoq_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import svoq_pkg::*;

  logic q_full;
  logic q_empty;
  logic enq;
  logic q_pop;
  cmd_t enq_data;
  cmd_t q_data;

  svoq_front #(
    .NODE_WORDS (NODE_WORDS),
    .LEAF_WORDS (LEAF_WORDS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .kind      (kind),
    .address   (address),
    .word      (word),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .enq       (enq),
    .enq_data  (enq_data)
  );

  svoq_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq),
    .wr_data (enq_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  svoq_back #(
    .NODE_WORDS (NODE_WORDS),
    .LEAF_WORDS (LEAF_WORDS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .solid   (solid)
  );

  assign full = q_full;

endmodule

FILE: design/svoq_front.sv
// Front end: holds the configuration registers, takes input beats and turns
// them into queue commands. Depends on svoq_pkg.
module svoq_front #(
  parameter int NODE_WORDS = 4096,
  parameter int LEAF_WORDS = 8192,
  parameter int MAX_DEPTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic [svoq_pkg::KIND_W-1:0]          kind,
  input  logic [svoq_pkg::ADDR_W-1:0]          address,
  input  logic [svoq_pkg::WORD_W-1:0]          word,
  input  logic signed [svoq_pkg::COORD_W-1:0]  coord_x,
  input  logic signed [svoq_pkg::COORD_W-1:0]  coord_y,
  input  logic signed [svoq_pkg::COORD_W-1:0]  coord_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [svoq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [svoq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_full,
  output logic                                 enq,
  output svoq_pkg::cmd_t                       enq_data
);
  import svoq_pkg::*;

  logic [DEPTH_W-1:0] tree_depth;
  logic [COORD_W-1:0] size_x;
  logic [COORD_W-1:0] size_y;
  logic [COORD_W-1:0] size_z;
  logic               tree_present;

  logic               accept;
  logic               keep;
  logic               in_grid;
  logic [DEPTH_W-1:0] depth_eff;
  logic [COORD_W-1:0] ux;
  logic [COORD_W-1:0] uy;
  logic [COORD_W-1:0] uz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_depth   <= '0;
      size_x       <= COORD_W'(1);
      size_y       <= COORD_W'(1);
      size_z       <= COORD_W'(1);
      tree_present <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TREE_DEPTH:   tree_depth   <= cfg_data[DEPTH_W-1:0];
        CFG_SIZE_X:       size_x       <= cfg_data[COORD_W-1:0];
        CFG_SIZE_Y:       size_y       <= cfg_data[COORD_W-1:0];
        CFG_SIZE_Z:       size_z       <= cfg_data[COORD_W-1:0];
        CFG_TREE_PRESENT: tree_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ux = $unsigned(coord_x);
  assign uy = $unsigned(coord_y);
  assign uz = $unsigned(coord_z);

  assign in_grid = !ux[COORD_W-1] && (ux < size_x)
                && !uy[COORD_W-1] && (uy < size_y)
                && !uz[COORD_W-1] && (uz < size_z);

  assign depth_eff = (tree_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : tree_depth;

  assign accept = push && !q_full;

  always_comb begin
    keep             = 1'b0;
    enq_data.op      = OP_ZERO;
    enq_data.address = address;
    enq_data.word    = word;
    enq_data.depth   = depth_eff;
    enq_data.x       = ux[POS_W-1:0];
    enq_data.y       = uy[POS_W-1:0];
    enq_data.z       = uz[POS_W-1:0];
    case (kind)
      KIND_NODE_WR: begin
        enq_data.op = OP_NODE_WR;
        keep        = 32'(address) < 32'(NODE_WORDS);
      end
      KIND_LEAF_WR: begin
        enq_data.op = OP_LEAF_WR;
        keep        = 32'(address) < 32'(LEAF_WORDS);
      end
      KIND_QUERY: begin
        enq_data.op = (tree_present && in_grid) ? OP_WALK : OP_ZERO;
        keep        = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign enq = accept && keep;

endmodule

FILE: design/svoq_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on svoq_pkg for the command type and queue depth.
module svoq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  svoq_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output svoq_pkg::cmd_t rd_data,
  output logic           empty
);
  import svoq_pkg::*;

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full    = count == CMD_CNT_W'(CMD_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("command queue count did not advance on write");
  a_count_drop: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> count == $past(count) - 1'b1)
    else $error("command queue count did not drop on read");
`endif

endmodule

FILE: design/svoq_back.sv
// Back end: node and leaf stores, the level-by-level walk and the result register.
// Depends on svoq_pkg; takes commands from svoq_cmd_fifo.
module svoq_back #(
  parameter int NODE_WORDS = 4096,
  parameter int LEAF_WORDS = 8192,
  parameter int MAX_DEPTH  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  svoq_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic           solid
);
  import svoq_pkg::*;

  localparam int NA_W = (NODE_WORDS > 1) ? $clog2(NODE_WORDS) : 1;
  localparam int LA_W = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_NODE = 3'b010,
    S_LEAF = 3'b100
  } state_t;

  logic [WORD_W-1:0] node_mem [NODE_WORDS];
  logic [WORD_W-1:0] leaf_mem [LEAF_WORDS];

  state_t             state;
  state_t             state_next;
  logic [DEPTH_W-1:0] level;
  logic [POS_W-1:0]   qx;
  logic [POS_W-1:0]   qy;
  logic [POS_W-1:0]   qz;
  logic [WORD_W-1:0]  node_rdata;
  logic [WORD_W-1:0]  leaf_rdata;
  logic               res_valid;
  logic               res_solid;

  logic               node_wr;
  logic               leaf_wr;
  logic               node_rd;
  logic               leaf_rd;
  logic [NA_W-1:0]    node_rd_addr;
  logic               start_walk;
  logic               res_load;
  logic               res_value;

  logic [MASK_W-1:0]  mask;
  logic [BASE_W-1:0]  base;
  logic [DEPTH_W-1:0] lvl_m1;
  logic [2:0]         octant;
  logic [MASK_W-1:0]  lower;
  logic [3:0]         pc;
  logic [BASE_W:0]    child;
  logic [BASE_W:0]    leaf_idx;
  logic [5:0]         bitn;
  logic [POS_W-3:0]   bx;
  logic [POS_W-3:0]   by;
  logic [POS_W-3:0]   bz;

  assign mask     = node_rdata[WORD_W-1 -: MASK_W];
  assign base     = node_rdata[BASE_W-1:0];
  assign lvl_m1   = level - 1'b1;
  assign bx       = qx[POS_W-1:2];
  assign by       = qy[POS_W-1:2];
  assign bz       = qz[POS_W-1:2];
  assign octant   = {bz[lvl_m1[3:0]], by[lvl_m1[3:0]], bx[lvl_m1[3:0]]};
  assign lower    = mask & ((MASK_W'(1) << octant) - MASK_W'(1));
  assign pc       = 4'($countones(lower));
  assign child    = {1'b0, base} + (BASE_W + 1)'(pc);
  assign bitn     = {qz[1:0], qy[1:0], qx[1:0]};
  assign leaf_idx = {base, bitn[5]};

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    node_wr      = 1'b0;
    leaf_wr      = 1'b0;
    node_rd      = 1'b0;
    leaf_rd      = 1'b0;
    node_rd_addr = '0;
    start_walk   = 1'b0;
    res_load     = 1'b0;
    res_value    = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          case (q_data.op)
            OP_NODE_WR: begin
              q_pop   = 1'b1;
              node_wr = 1'b1;
            end
            OP_LEAF_WR: begin
              q_pop   = 1'b1;
              leaf_wr = 1'b1;
            end
            OP_ZERO: begin
              if (!res_valid) begin
                q_pop    = 1'b1;
                res_load = 1'b1;
              end
            end
            OP_WALK: begin
              if (!res_valid) begin
                q_pop      = 1'b1;
                start_walk = 1'b1;
                node_rd    = 1'b1;
                state_next = S_NODE;
              end
            end
            default: ;
          endcase
        end
      end
      S_NODE: begin
        if (node_rdata == FULL_NODE) begin
          res_load   = 1'b1;
          res_value  = 1'b1;
          state_next = S_IDLE;
        end else if (level != '0 && mask != '0) begin
          if (!mask[octant]) begin
            res_load   = 1'b1;
            state_next = S_IDLE;
          end else if (32'(child) >= 32'(NODE_WORDS)) begin
            res_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            node_rd      = 1'b1;
            node_rd_addr = NA_W'(child);
          end
        end else if (32'(leaf_idx) >= 32'(LEAF_WORDS)) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          leaf_rd    = 1'b1;
          state_next = S_LEAF;
        end
      end
      S_LEAF: begin
        res_load   = 1'b1;
        res_value  = leaf_rdata[bitn[4:0]];
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_wr) begin
      node_mem[NA_W'(q_data.address)] <= q_data.word;
    end
    if (node_rd) begin
      node_rdata <= node_mem[node_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (leaf_wr) begin
      leaf_mem[LA_W'(q_data.address)] <= q_data.word;
    end
    if (leaf_rd) begin
      leaf_rdata <= leaf_mem[LA_W'(leaf_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (start_walk) begin
      qx <= q_data.x;
      qy <= q_data.y;
      qz <= q_data.z;
    end
    if (res_load) begin
      res_solid <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      level     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_walk) begin
        level <= q_data.depth;
      end else if (state == S_NODE && node_rd) begin
        level <= lvl_m1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign empty = !res_valid;
  assign solid = res_solid;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid)
    else $error("result register overwritten while held");
  a_leaf_after_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_LEAF) |-> $past(state == S_NODE))
    else $error("leaf stage entered without a node stage");
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_NODE) |-> level <= DEPTH_W'(MAX_DEPTH))
    else $error("walk level beyond maximum depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");
`endif

endmodule

FILE: dv/tb_sparse_voxel_octree_query_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for sparse_voxel_octree_query_unit: builds octrees by write beats,
// queries voxels and checks every solid bit against its own octree walk.
// Depends on svoq_pkg and the design top level only.

localparam int NODE_WORDS   = 4096;
localparam int LEAF_WORDS   = 8192;
localparam int MAX_DEPTH    = 16;
localparam logic [1:0] KIND_IGNORED = 2'd3;

class voxel_scoreboard;
  bit [31:0] node_mem [NODE_WORDS];
  bit        node_set [NODE_WORDS];
  bit [31:0] leaf_mem [LEAF_WORDS];
  bit        leaf_set [LEAF_WORDS];
  bit [4:0]  depth_reg;
  bit [18:0] size_reg [3];
  bit        present_reg;
  bit        solid_due [$];
  int        mismatches;

  function new();
    depth_reg   = '0;
    size_reg    = '{19'd1, 19'd1, 19'd1};
    present_reg = 1'b0;
    mismatches  = 0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [18:0] data);
    case (idx)
      svoq_pkg::CFG_TREE_DEPTH:   depth_reg = data[4:0];
      svoq_pkg::CFG_SIZE_X:       size_reg[0] = data;
      svoq_pkg::CFG_SIZE_Y:       size_reg[1] = data;
      svoq_pkg::CFG_SIZE_Z:       size_reg[2] = data;
      svoq_pkg::CFG_TREE_PRESENT: present_reg = data[0];
      default: ;
    endcase
  endfunction

  // Walk the octree; unsure is raised when the walk reads an unwritten entry.
  function bit occupancy(bit [17:0] x, bit [17:0] y, bit [17:0] z, output bit unsure);
    bit [15:0]       bx, by, bz;
    int              top;
    longint unsigned idx, leaf;
    bit [31:0]       n;
    bit [7:0]        m;
    bit [2:0]        oct;
    bit [5:0]        pos;
    unsure = 0;
    bx = x[17:2];
    by = y[17:2];
    bz = z[17:2];
    top = depth_reg > MAX_DEPTH ? MAX_DEPTH : depth_reg;
    idx = 0;
    for (int lvl = top - 1; lvl >= 0; lvl--) begin
      if (idx >= NODE_WORDS) return 0;
      unsure |= !node_set[idx];
      n = node_mem[idx];
      if (n == svoq_pkg::FULL_NODE) return 1;
      m = n[31:24];
      if (m == 0) break;
      oct = {bz[lvl], by[lvl], bx[lvl]};
      if (!m[oct]) return 0;
      idx = longint'(n[23:0]) + $countones(m & ((8'd1 << oct) - 8'd1));
    end
    if (idx >= NODE_WORDS) return 0;
    unsure |= !node_set[idx];
    n = node_mem[idx];
    if (n == svoq_pkg::FULL_NODE) return 1;
    pos = {z[1:0], y[1:0], x[1:0]};
    leaf = longint'(n[23:0]) * 2 + pos[5];
    if (leaf >= LEAF_WORDS) return 0;
    unsure |= !leaf_set[leaf];
    return leaf_mem[leaf][pos[4:0]];
  endfunction

  function bit answer(bit [18:0] cx, bit [18:0] cy, bit [18:0] cz, output bit unsure);
    unsure = 0;
    if (!present_reg) return 0;
    if (cx[18] || cx >= size_reg[0] || cy[18] || cy >= size_reg[1]
        || cz[18] || cz >= size_reg[2]) return 0;
    return occupancy(cx[17:0], cy[17:0], cz[17:0], unsure);
  endfunction

  function void note_beat(bit [1:0] k, bit [12:0] a, bit [31:0] w,
                          bit [18:0] cx, bit [18:0] cy, bit [18:0] cz);
    bit unsure;
    bit due;
    case (k)
      svoq_pkg::KIND_NODE_WR: begin
        if (a < NODE_WORDS) begin
          node_mem[a] = w;
          node_set[a] = 1;
        end
      end
      svoq_pkg::KIND_LEAF_WR: begin
        if (a < LEAF_WORDS) begin
          leaf_mem[a] = w;
          leaf_set[a] = 1;
        end
      end
      svoq_pkg::KIND_QUERY: begin
        due = answer(cx, cy, cz, unsure);
        solid_due = {solid_due, due};
      end
      default: ;
    endcase
  endfunction

  function void check_solid(logic actual);
    bit due;
    if (solid_due.size() == 0) begin
      mismatches++;
      $error("solid: expected none, actual %0b", actual);
      return;
    end
    due = solid_due.pop_front();
    if (actual !== due) begin
      mismatches++;
      $error("solid: expected %0b, actual %0b", due, actual);
    end
  endfunction

  function int waiting();
    return solid_due.size();
  endfunction
endclass

module tb_sparse_voxel_octree_query_unit;
  localparam int SETTLE      = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 65;
  localparam int TREE_BUDGET = 24;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind = '0;
  logic [12:0] address = '0;
  logic [31:0] word = '0;
  logic signed [18:0] coord_x = '0;
  logic signed [18:0] coord_y = '0;
  logic signed [18:0] coord_z = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        solid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [18:0] cfg_data = '0;

  bit src_calm = 0;
  bit sink_calm = 0;
  voxel_scoreboard sb;

  wire moving = (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready);

  sparse_voxel_octree_query_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind), .address(address),
    .word(word), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .empty(empty), .pop(pop), .solid(solid), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic offer(bit [1:0] k, bit [12:0] a, bit [31:0] w,
                       bit [18:0] cx, bit [18:0] cy, bit [18:0] cz);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    address <= a;
    word <= w;
    coord_x <= cx;
    coord_y <= cy;
    coord_z <= cz;
    do @(posedge clk); while (full);
    sb.note_beat(k, a, w, cx, cy, cz);
  endtask

  task automatic write_node(bit [12:0] a, bit [31:0] w);
    offer(svoq_pkg::KIND_NODE_WR, a, w, 19'($urandom), 19'($urandom), 19'($urandom));
  endtask

  task automatic write_leaf(bit [12:0] a, bit [31:0] w);
    offer(svoq_pkg::KIND_LEAF_WR, a, w, 19'($urandom), 19'($urandom), 19'($urandom));
  endtask

  task automatic ask(bit [18:0] cx, bit [18:0] cy, bit [18:0] cz);
    offer(svoq_pkg::KIND_QUERY, 13'($urandom), $urandom, cx, cy, cz);
  endtask

  // Hold the sender until every solid bit is back; optionally let trailing writes drain.
  task automatic settle(bit drain_writes);
    push <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
    if (drain_writes) repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(bit [4:0] d, bit [18:0] sx, bit [18:0] sy, bit [18:0] sz,
                           bit on);
    bit [2:0]  idx [5];
    bit [18:0] val [5];
    idx = '{svoq_pkg::CFG_TREE_DEPTH, svoq_pkg::CFG_SIZE_X, svoq_pkg::CFG_SIZE_Y,
            svoq_pkg::CFG_SIZE_Z, svoq_pkg::CFG_TREE_PRESENT};
    val[0] = 19'(d);
    val[1] = sx;
    val[2] = sy;
    val[3] = sz;
    val[4] = 19'(on);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Build a fresh tree from node 0 breadth first, each leaf block with its own leaf pair.
  task automatic grow_tree(int d);
    int        q_idx [$];
    int        q_rem [$];
    int        next_node, next_pair, cur, rem, pc, pick;
    bit [31:0] w;
    bit [31:0] lw;
    bit [7:0]  m;
    bit [7:0]  junk;
    next_node = 1;
    next_pair = $urandom_range(0, 1000);
    q_idx = {q_idx, 0};
    q_rem = {q_rem, d};
    while (q_idx.size() > 0) begin
      cur = q_idx.pop_front();
      rem = q_rem.pop_front();
      m = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 3) < (d > 4 ? 3 : 1)) m = 8'd1 << $urandom_range(0, 7);
      pc = $countones(m);
      if ($urandom_range(0, 9) == 0) begin
        w = svoq_pkg::FULL_NODE;
      end else if (rem == 0 || next_node + pc > TREE_BUDGET
                   || $urandom_range(0, 11) == 0) begin
        junk = 8'($urandom);
        w = {rem == 0 ? junk : 8'h00, 24'(next_pair)};
        for (int h = 0; h < 2; h++) begin
          pick = $urandom_range(0, 7);
          lw = pick == 0 ? 32'h0 : pick == 1 ? 32'hffffffff : $urandom;
          write_leaf(13'(next_pair * 2 + h), lw);
        end
        next_pair++;
      end else begin
        w = {m, 24'(next_node)};
        for (int k = 0; k < pc; k++) begin
          q_idx = {q_idx, next_node + k};
          q_rem = {q_rem, rem - 1};
        end
        next_node += pc;
      end
      write_node(13'(cur), w);
    end
  endtask

  // Steer a voxel down populated octants, with an occasional turn into a missing child.
  function automatic void aim(int d, bit roam, output bit [17:0] x, output bit [17:0] y,
                              output bit [17:0] z);
    bit [15:0]       bx, by, bz;
    longint unsigned idx;
    bit [31:0]       n;
    bit [7:0]        m;
    bit [2:0]        oct;
    bit              live;
    bx = roam ? 16'($urandom) : 16'd0;
    by = roam ? 16'($urandom) : 16'd0;
    bz = roam ? 16'($urandom) : 16'd0;
    idx = 0;
    live = 1;
    for (int lvl = d - 1; lvl >= 0; lvl--) begin
      oct = 3'($urandom_range(0, 7));
      if (live && idx < NODE_WORDS && sb.node_set[idx]) begin
        n = sb.node_mem[idx];
        m = n[31:24];
        if (n == svoq_pkg::FULL_NODE || m == 0) begin
          live = 0;
        end else begin
          if ($urandom_range(0, 5) != 0)
            while (!m[oct]) oct = 3'($urandom_range(0, 7));
          if (m[oct]) idx = longint'(n[23:0]) + $countones(m & ((8'd1 << oct) - 8'd1));
          else live = 0;
        end
      end else begin
        live = 0;
      end
      bx[lvl] = oct[0];
      by[lvl] = oct[1];
      bz[lvl] = oct[2];
    end
    x = {bx, 2'($urandom_range(0, 3))};
    y = {by, 2'($urandom_range(0, 3))};
    z = {bz, 2'($urandom_range(0, 3))};
  endfunction

  task automatic send_query(int d);
    bit [18:0] cx, cy, cz;
    bit [17:0] px, py, pz;
    bit        unsure;
    int        tries;
    tries = 0;
    do begin
      aim(d, $urandom_range(0, 7) == 0, px, py, pz);
      cx = {1'b0, px};
      cy = {1'b0, py};
      cz = {1'b0, pz};
      case ($urandom_range(0, 9))
        0: begin
          cx = 19'($urandom);
          cy = 19'($urandom);
          cz = 19'($urandom);
        end
        1: cz = sb.size_reg[2];
        default: ;
      endcase
      void'(sb.answer(cx, cy, cz, unsure));
      tries++;
    end while (unsure && tries < 16);
    // fall back to a voxel left of the grid
    if (unsure) cx = 19'h7ffff;
    ask(cx, cy, cz);
  endtask

  task automatic noise();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8)
      write_node(13'($urandom_range(NODE_WORDS, 8191)), $urandom);
    else if (r < 10)
      write_node(13'($urandom), $urandom);
    else if (r < 15)
      write_leaf(13'($urandom), $urandom);
    else
      offer(KIND_IGNORED, 13'($urandom), $urandom, 19'($urandom), 19'($urandom),
            19'($urandom));
  endtask

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_solid(solid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (moving) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int        d_reg, d, span, pause_at;
    bit [18:0] sz [3];
    int        depth_plan [10];
    sb = new();
    depth_plan = '{0, 1, 2, 3, 16, 4, 6, 20, 31, 2};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no tree, so every query is empty
    ask(19'd0, 19'd0, 19'd0);
    ask(19'h40000, 19'h3ffff, 19'd0);
    offer(KIND_IGNORED, 13'h1fff, 32'hffffffff, 19'h7ffff, 19'h7ffff, 19'h7ffff);
    write_node(13'h1fff, 32'hffffffff);
    settle(1);

    // single leaf block, root selects leaf pair 0
    configure(5'd0, 19'd4, 19'd4, 19'd4, 1'b1);
    write_node(13'd0, 32'h0);
    write_leaf(13'd0, 32'hffffffff);
    write_leaf(13'd1, 32'h0);
    ask(19'd0, 19'd0, 19'd0);
    ask(19'd3, 19'd3, 19'd3);
    ask(19'd3, 19'd3, 19'd1);
    ask(19'd4, 19'd0, 19'd0);
    ask(19'd0, 19'h7ffff, 19'd0);
    write_node(13'd0, svoq_pkg::FULL_NODE);
    ask(19'd1, 19'd2, 19'd3);
    write_node(13'd0, {8'h00, 24'd4096});
    ask(19'd0, 19'd0, 19'd0);
    write_node(13'd0, 32'hffffffff);
    ask(19'd2, 19'd1, 19'd0);
    settle(1);

    // one level: child index overflow, missing child, full child, zero child mask
    configure(5'd1, 19'd8, 19'd8, 19'd8, 1'b1);
    write_node(13'd0, {8'h01, 24'hffffff});
    ask(19'd0, 19'd0, 19'd0);
    write_node(13'd0, {8'h81, 24'd1});
    write_node(13'd1, {8'h00, 24'd1});
    write_node(13'd2, svoq_pkg::FULL_NODE);
    write_leaf(13'd2, $urandom);
    write_leaf(13'd3, $urandom);
    ask(19'd1, 19'd2, 19'd3);
    ask(19'd7, 19'd7, 19'd7);
    ask(19'd4, 19'd0, 19'd0);
    write_node(13'd0, {8'h00, 24'd1});
    ask(19'd5, 19'd5, 19'd5);

    for (int p = 0; p < 10; p++) begin
      settle(1);
      src_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      d_reg = depth_plan[p];
      d = d_reg > MAX_DEPTH ? MAX_DEPTH : d_reg;
      span = 4 << d;
      for (int a = 0; a < 3; a++)
        sz[a] = $urandom_range(0, 1) ? 19'(span) : 19'($urandom_range(1, span));
      case (p)
        3: sz = '{19'h7ffff, 19'h7ffff, 19'h7ffff};
        6: sz[1] = 19'd0;
        9: sz[0] = 19'd1;
        default: ;
      endcase
      configure(5'(d_reg), sz[0], sz[1], sz[2], p != 5);
      grow_tree(d);
      pause_at = $urandom_range(5, PHASE_ITEMS - 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) settle(0);
        if ($urandom_range(0, 4) != 0) send_query(d);
        else noise();
      end
    end

    settle(1);
    if (sb.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: sparse_voxel_octree_query_unit.f
design/svoq_pkg.sv
design/svoq_front.sv
design/svoq_cmd_fifo.sv
design/svoq_back.sv
design/sparse_voxel_octree_query_unit.sv
dv/tb_sparse_voxel_octree_query_unit.sv
